// ===== src/zlhp_pkg.sv =====
// ----------------------------------------------------------------------------
// zlhp_pkg
// Shared codes and constants of the ZIP local header parser.
// ----------------------------------------------------------------------------
package zlhp_pkg;

    localparam logic [31:0] SIG_LOCAL    = 32'h0403_4b50;
    localparam logic [15:0] ID_TIMESTAMP = 16'h5455;
    localparam logic [15:0] ID_UNIX      = 16'h7875;
    localparam logic [11:0] YEAR_BASE    = 12'd1980;

    typedef enum logic [3:0] {
        FC_VERSION   = 4'd0,
        FC_FLAGS     = 4'd1,
        FC_METHOD    = 4'd2,
        FC_TIME      = 4'd3,
        FC_DATE      = 4'd4,
        FC_CRC       = 4'd5,
        FC_CSIZE     = 4'd6,
        FC_USIZE     = 4'd7,
        FC_NAMELEN   = 4'd8,
        FC_EXTRALEN  = 4'd9,
        FC_NAMEBYTE  = 4'd10,
        FC_EXTRAID   = 4'd11,
        FC_EXTRASUB  = 4'd12,
        FC_BADSIG    = 4'd13,
        FC_END       = 4'd14
    } field_code_t;

    typedef enum logic [11:0] {
        XK_TIMESTAMP = 12'd0,
        XK_UNIX      = 12'd1,
        XK_OTHER     = 12'd2
    } extra_kind_t;

endpackage

// ===== src/zip_local_header_parser_unit.sv =====
// ----------------------------------------------------------------------------
// zip_local_header_parser_unit
// Byte-serial parser for a chain of ZIP local file headers.
// ----------------------------------------------------------------------------
// A result is registered from the beat that completes it.
// Throughput: one byte per cycle unless a held result is stalled; the output
// register takes a new result while the previous one is taken in the same cycle.
// Reset: synchronous active-low aresetn returns to awaiting a signature,
// clears all counters and the stop flag, and empties the output register.
module zip_local_header_parser_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_byte_value,
    input  logic        s_stream_end,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [3:0]  m_field_code,
    output logic [31:0] m_field_value,
    output logic [11:0] m_hour_or_year,
    output logic [5:0]  m_minute_or_month,
    output logic [5:0]  m_second_or_day
);

    typedef enum logic [3:0] {
        PH_SIG, PH_VERSION, PH_FLAGS, PH_METHOD, PH_TIME, PH_DATE, PH_CRC,
        PH_CSIZE, PH_USIZE, PH_NAMELEN, PH_EXTRALEN, PH_NAME, PH_XID,
        PH_XLEN, PH_XSKIP, PH_DSKIP
    } phase_t;

    function automatic phase_t after_extras(input logic [15:0] xr, input logic [31:0] cl);
        phase_t ph;
        if (xr != 16'd0) begin
            ph = PH_XID;
        end else if (cl != 32'd0) begin
            ph = PH_DSKIP;
        end else begin
            ph = PH_SIG;
        end
        return ph;
    endfunction

    phase_t      phase_reg, phase_next;
    logic [1:0]  bif_reg, bif_next;
    logic [31:0] shift_reg, shift_next;
    logic [31:0] csize_reg, csize_next;
    logic [15:0] name_reg, name_next;
    logic [15:0] extra_reg, extra_next;
    logic [31:0] skip_reg, skip_next;
    logic        stopped_reg, stopped_next;

    logic        m_valid_reg;
    logic [3:0]  code_reg, code_next;
    logic [31:0] value_reg, value_next;
    logic [11:0] hy_reg, hy_next;
    logic [5:0]  mm_reg, mm_next;
    logic [5:0]  sd_reg, sd_next;
    logic        emit;
    logic        accept;

    logic        is_long;
    logic        last_byte;
    logic [31:0] assembled;
    logic [15:0] v16;
    logic [16:0] sub_total;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    assign is_long = (phase_reg == PH_SIG) || (phase_reg == PH_CRC) ||
                     (phase_reg == PH_CSIZE) || (phase_reg == PH_USIZE);
    assign last_byte = is_long ? (bif_reg == 2'd3) : (bif_reg == 2'd1);
    assign v16       = assembled[15:0];
    assign sub_total = {1'b0, v16} + 17'd4;

    always_comb begin
        unique case (bif_reg)
            2'd0: assembled = {24'd0, s_byte_value};
            2'd1: assembled = {shift_reg[31:16], s_byte_value, shift_reg[7:0]};
            2'd2: assembled = {shift_reg[31:24], s_byte_value, shift_reg[15:0]};
            2'd3: assembled = {s_byte_value, shift_reg[23:0]};
        endcase
    end

    always_comb begin
        phase_next   = phase_reg;
        bif_next     = bif_reg;
        shift_next   = shift_reg;
        csize_next   = csize_reg;
        name_next    = name_reg;
        extra_next   = extra_reg;
        skip_next    = skip_reg;
        stopped_next = stopped_reg;
        emit         = 1'b0;
        code_next    = zlhp_pkg::FC_END;
        value_next   = 32'd0;
        hy_next      = 12'd0;
        mm_next      = 6'd0;
        sd_next      = 6'd0;
        if (!stopped_reg) begin
            if (s_stream_end) begin
                stopped_next = 1'b1;
                emit         = 1'b1;
            end else begin
                unique case (phase_reg)
                    PH_NAME: begin
                        name_next  = name_reg - 16'd1;
                        emit       = 1'b1;
                        code_next  = zlhp_pkg::FC_NAMEBYTE;
                        value_next = {24'd0, s_byte_value};
                        if (name_next == 16'd0) begin
                            phase_next = after_extras(extra_reg, csize_reg);
                            if (phase_next == PH_DSKIP) begin
                                skip_next = csize_reg;
                            end
                        end
                    end
                    PH_XSKIP, PH_DSKIP: begin
                        skip_next = skip_reg - 32'd1;
                        if (skip_next == 32'd0) begin
                            if (phase_reg == PH_XSKIP) begin
                                phase_next = after_extras(extra_reg, csize_reg);
                                if (phase_next == PH_DSKIP) begin
                                    skip_next = csize_reg;
                                end
                            end else begin
                                phase_next = PH_SIG;
                            end
                        end
                    end
                    default: begin
                        shift_next = assembled;
                        if (!last_byte) begin
                            bif_next = bif_reg + 2'd1;
                        end else begin
                            bif_next   = 2'd0;
                            emit       = 1'b1;
                            value_next = assembled;
                            unique case (phase_reg)
                                PH_SIG: begin
                                    if (assembled == 32'd0) begin
                                        stopped_next = 1'b1;
                                        code_next    = zlhp_pkg::FC_END;
                                    end else if (assembled != zlhp_pkg::SIG_LOCAL) begin
                                        stopped_next = 1'b1;
                                        code_next    = zlhp_pkg::FC_BADSIG;
                                    end else begin
                                        emit       = 1'b0;
                                        phase_next = PH_VERSION;
                                    end
                                    if (assembled == 32'd0) begin
                                        value_next = 32'd0;
                                    end
                                end
                                PH_VERSION: begin
                                    phase_next = PH_FLAGS;
                                    code_next  = zlhp_pkg::FC_VERSION;
                                end
                                PH_FLAGS: begin
                                    phase_next = PH_METHOD;
                                    code_next  = zlhp_pkg::FC_FLAGS;
                                end
                                PH_METHOD: begin
                                    phase_next = PH_TIME;
                                    code_next  = zlhp_pkg::FC_METHOD;
                                end
                                PH_TIME: begin
                                    phase_next = PH_DATE;
                                    code_next  = zlhp_pkg::FC_TIME;
                                    hy_next    = {7'd0, v16[15:11]};
                                    mm_next    = v16[10:5];
                                    sd_next    = {v16[4:0], 1'b0};
                                end
                                PH_DATE: begin
                                    phase_next = PH_CRC;
                                    code_next  = zlhp_pkg::FC_DATE;
                                    hy_next    = {5'd0, v16[15:9]} + zlhp_pkg::YEAR_BASE;
                                    mm_next    = {2'd0, v16[8:5]};
                                    sd_next    = {1'b0, v16[4:0]};
                                end
                                PH_CRC: begin
                                    phase_next = PH_CSIZE;
                                    code_next  = zlhp_pkg::FC_CRC;
                                end
                                PH_CSIZE: begin
                                    csize_next = assembled;
                                    phase_next = PH_USIZE;
                                    code_next  = zlhp_pkg::FC_CSIZE;
                                end
                                PH_USIZE: begin
                                    phase_next = PH_NAMELEN;
                                    code_next  = zlhp_pkg::FC_USIZE;
                                end
                                PH_NAMELEN: begin
                                    name_next  = v16;
                                    phase_next = PH_EXTRALEN;
                                    code_next  = zlhp_pkg::FC_NAMELEN;
                                end
                                PH_EXTRALEN: begin
                                    extra_next = v16;
                                    code_next  = zlhp_pkg::FC_EXTRALEN;
                                    if (name_reg != 16'd0) begin
                                        phase_next = PH_NAME;
                                    end else begin
                                        phase_next = after_extras(v16, csize_reg);
                                        if (phase_next == PH_DSKIP) begin
                                            skip_next = csize_reg;
                                        end
                                    end
                                end
                                PH_XID: begin
                                    phase_next = PH_XLEN;
                                    code_next  = zlhp_pkg::FC_EXTRAID;
                                    if (v16 == zlhp_pkg::ID_TIMESTAMP) begin
                                        hy_next = zlhp_pkg::XK_TIMESTAMP;
                                    end else if (v16 == zlhp_pkg::ID_UNIX) begin
                                        hy_next = zlhp_pkg::XK_UNIX;
                                    end else begin
                                        hy_next = zlhp_pkg::XK_OTHER;
                                    end
                                end
                                PH_XLEN: begin
                                    code_next = zlhp_pkg::FC_EXTRASUB;
                                    if (sub_total >= {1'b0, extra_reg}) begin
                                        extra_next = 16'd0;
                                    end else begin
                                        extra_next = extra_reg - sub_total[15:0];
                                    end
                                    skip_next = {16'd0, v16};
                                    if (v16 != 16'd0) begin
                                        phase_next = PH_XSKIP;
                                    end else begin
                                        phase_next = after_extras(extra_next, csize_reg);
                                        if (phase_next == PH_DSKIP) begin
                                            skip_next = csize_reg;
                                        end
                                    end
                                end
                                default: begin
                                    emit = 1'b0;
                                end
                            endcase
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_SIG;
            bif_reg     <= 2'd0;
            shift_reg   <= 32'd0;
            csize_reg   <= 32'd0;
            name_reg    <= 16'd0;
            extra_reg   <= 16'd0;
            skip_reg    <= 32'd0;
            stopped_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept && emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (accept) begin
                phase_reg   <= phase_next;
                bif_reg     <= bif_next;
                shift_reg   <= shift_next;
                csize_reg   <= csize_next;
                name_reg    <= name_next;
                extra_reg   <= extra_next;
                skip_reg    <= skip_next;
                stopped_reg <= stopped_next;
            end
        end
        if (accept && emit) begin
            code_reg  <= code_next;
            value_reg <= value_next;
            hy_reg    <= hy_next;
            mm_reg    <= mm_next;
            sd_reg    <= sd_next;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_field_code      = code_reg;
    assign m_field_value     = value_reg;
    assign m_hour_or_year    = hy_reg;
    assign m_minute_or_month = mm_reg;
    assign m_second_or_day   = sd_reg;

endmodule

// ===== src/zlhp_checker.sv =====
// ----------------------------------------------------------------------------
// zlhp_checker
// Port-level checks of the ZIP local header parser, bound to the top level.
// ----------------------------------------------------------------------------
module zlhp_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [3:0]  m_field_code,
    input logic [31:0] m_field_value,
    input logic [11:0] m_hour_or_year,
    input logic [5:0]  m_minute_or_month,
    input logic [5:0]  m_second_or_day
);

    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_field_code) &&
                                   $stable(m_field_value)))
        else $error("stalled result changed");

    a_silent_after_stop: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && (m_field_code == zlhp_pkg::FC_END ||
                                m_field_code == zlhp_pkg::FC_BADSIG)) |=> !m_valid)
        else $error("result after parsing stopped");

    a_parts_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_field_code != zlhp_pkg::FC_TIME &&
         m_field_code != zlhp_pkg::FC_DATE && m_field_code != zlhp_pkg::FC_EXTRAID)
        |-> (m_hour_or_year == 12'd0 && m_minute_or_month == 6'd0 &&
             m_second_or_day == 6'd0))
        else $error("split parts set on a plain field");

    a_end_value: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_field_code == zlhp_pkg::FC_END) |-> (m_field_value == 32'd0))
        else $error("end result carries a value");

    a_extra_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_field_code == zlhp_pkg::FC_EXTRAID)
        |-> (m_hour_or_year <= 12'd2 && m_field_value[31:16] == 16'd0))
        else $error("bad extra id result");

endmodule

bind zip_local_header_parser_unit zlhp_checker u_zlhp_checker (
    .aclk              (aclk),
    .aresetn           (aresetn),
    .m_valid           (m_valid),
    .m_ready           (m_ready),
    .m_field_code      (m_field_code),
    .m_field_value     (m_field_value),
    .m_hour_or_year    (m_hour_or_year),
    .m_minute_or_month (m_minute_or_month),
    .m_second_or_day   (m_second_or_day)
);

// ===== sim/tb_zip_local_header_parser_unit.sv =====
// ----------------------------------------------------------------------------
// tb_zip_local_header_parser_unit
// Self-checking bench for the byte-serial ZIP local header parser. Feeds
// chains of well-formed local file headers with random content (names,
// extra fields, skipped data), then ends the stream one of several ways.
// A behavioral parser in the bench predicts every reported field; results
// are compared in order, field by field, under random stalls on both sides.
// ----------------------------------------------------------------------------
module tb_zip_local_header_parser_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_BYTES = 1450;
    localparam int TOTAL_BYTES  = 1550;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int PRINT_LIMIT  = 40;

    typedef enum logic [3:0] {
        ST_SIG, ST_VERSION, ST_FLAGS, ST_METHOD, ST_TIME, ST_DATE, ST_CRC, ST_CSIZE,
        ST_USIZE, ST_NAMELEN, ST_EXTRALEN, ST_NAME, ST_XID, ST_XLEN, ST_XSKIP, ST_DSKIP
    } parse_state_t;

    typedef struct packed {
        zlhp_pkg::field_code_t code;
        logic [31:0] value;
        logic [11:0] hour_year;
        logic [5:0]  min_month;
        logic [5:0]  sec_day;
    } hdr_field_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_byte_value = 8'h00;
    logic        s_stream_end = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [3:0]  m_field_code;
    logic [31:0] m_field_value;
    logic [11:0] m_hour_or_year;
    logic [5:0]  m_minute_or_month;
    logic [5:0]  m_second_or_day;

    zip_local_header_parser_unit dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_byte_value      (s_byte_value),
        .s_stream_end      (s_stream_end),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_field_code      (m_field_code),
        .m_field_value     (m_field_value),
        .m_hour_or_year    (m_hour_or_year),
        .m_minute_or_month (m_minute_or_month),
        .m_second_or_day   (m_second_or_day)
    );

    always #2 aclk = ~aclk;

    // parser state of the bench
    parse_state_t parse_st = ST_SIG;
    logic [1:0]   byte_idx = '0;
    logic [31:0]  shift_acc = '0;
    logic [31:0]  data_len = '0;
    logic [15:0]  name_left = '0;
    logic [15:0]  extra_left = '0;
    logic [31:0]  skip_left = '0;
    logic         halted = 1'b0;

    hdr_field_t pending_fields[$];
    int         fails = 0;
    int         fields_checked = 0;
    int         bytes_sent = 0;
    int         records_sent = 0;
    int         cycle_count = 0;
    int         stall_left = 0;
    bit         calm = 1'b0;
    string      ending_kind = "none";

    task automatic leave_extras();
        if (extra_left != 0) begin
            parse_st = ST_XID;
        end else if (data_len != 0) begin
            skip_left = data_len;
            parse_st  = ST_DSKIP;
        end else begin
            parse_st = ST_SIG;
        end
    endtask

    task automatic predict_header_field(input logic [7:0] b, input logic e,
                                        output bit has, output hdr_field_t r);
        logic [31:0] v;
        int          size;
        has = 1'b0;
        r   = '0;
        if (halted) return;
        if (e) begin
            halted = 1'b1;
            has    = 1'b1;
            r.code = zlhp_pkg::FC_END;
            return;
        end
        if (parse_st == ST_NAME) begin
            name_left = name_left - 16'd1;
            if (name_left == 0) leave_extras();
            has     = 1'b1;
            r.code  = zlhp_pkg::FC_NAMEBYTE;
            r.value = {24'h0, b};
            return;
        end
        if (parse_st == ST_XSKIP || parse_st == ST_DSKIP) begin
            skip_left = skip_left - 32'd1;
            if (skip_left == 0) begin
                if (parse_st == ST_XSKIP) leave_extras();
                else parse_st = ST_SIG;
            end
            return;
        end
        size = (parse_st == ST_SIG || parse_st == ST_CRC || parse_st == ST_CSIZE ||
                parse_st == ST_USIZE) ? 4 : 2;
        if (byte_idx == 0) shift_acc = '0;
        shift_acc = shift_acc | ({24'h0, b} << (8 * byte_idx));
        if (byte_idx + 1 < size) begin
            byte_idx = byte_idx + 2'd1;
            return;
        end
        byte_idx = '0;
        v        = shift_acc;
        has      = 1'b1;
        r.value  = v;
        case (parse_st)
            ST_SIG: begin
                halted = 1'b1;
                if (v == 0) begin
                    r.code = zlhp_pkg::FC_END;
                end else if (v != zlhp_pkg::SIG_LOCAL) begin
                    r.code = zlhp_pkg::FC_BADSIG;
                end else begin
                    halted   = 1'b0;
                    has      = 1'b0;
                    parse_st = ST_VERSION;
                end
            end
            ST_VERSION: begin
                r.code   = zlhp_pkg::FC_VERSION;
                parse_st = ST_FLAGS;
            end
            ST_FLAGS: begin
                r.code   = zlhp_pkg::FC_FLAGS;
                parse_st = ST_METHOD;
            end
            ST_METHOD: begin
                r.code   = zlhp_pkg::FC_METHOD;
                parse_st = ST_TIME;
            end
            ST_TIME: begin
                r.code      = zlhp_pkg::FC_TIME;
                r.hour_year = {7'h0, v[15:11]};
                r.min_month = v[10:5];
                r.sec_day   = {v[4:0], 1'b0};
                parse_st    = ST_DATE;
            end
            ST_DATE: begin
                r.code      = zlhp_pkg::FC_DATE;
                r.hour_year = {5'h0, v[15:9]} + zlhp_pkg::YEAR_BASE;
                r.min_month = {2'b0, v[8:5]};
                r.sec_day   = {1'b0, v[4:0]};
                parse_st    = ST_CRC;
            end
            ST_CRC: begin
                r.code   = zlhp_pkg::FC_CRC;
                parse_st = ST_CSIZE;
            end
            ST_CSIZE: begin
                r.code   = zlhp_pkg::FC_CSIZE;
                data_len = v;
                parse_st = ST_USIZE;
            end
            ST_USIZE: begin
                r.code   = zlhp_pkg::FC_USIZE;
                parse_st = ST_NAMELEN;
            end
            ST_NAMELEN: begin
                r.code    = zlhp_pkg::FC_NAMELEN;
                name_left = v[15:0];
                parse_st  = ST_EXTRALEN;
            end
            ST_EXTRALEN: begin
                r.code     = zlhp_pkg::FC_EXTRALEN;
                extra_left = v[15:0];
                if (name_left != 0) parse_st = ST_NAME;
                else leave_extras();
            end
            ST_XID: begin
                r.code = zlhp_pkg::FC_EXTRAID;
                if (v[15:0] == zlhp_pkg::ID_TIMESTAMP) r.hour_year = zlhp_pkg::XK_TIMESTAMP;
                else if (v[15:0] == zlhp_pkg::ID_UNIX) r.hour_year = zlhp_pkg::XK_UNIX;
                else r.hour_year = zlhp_pkg::XK_OTHER;
                parse_st = ST_XLEN;
            end
            default: begin
                r.code = zlhp_pkg::FC_EXTRASUB;
                if (v + 32'd4 >= {16'h0, extra_left}) extra_left = '0;
                else extra_left = extra_left - v[15:0] - 16'd4;
                skip_left = v;
                if (v != 0) parse_st = ST_XSKIP;
                else leave_extras();
            end
        endcase
    endtask

    // ------------------------------------------------------------------ sender
    task automatic send_byte(input logic [7:0] b, input logic e);
        bit         has;
        hdr_field_t f;
        if (!calm && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_byte_value <= b;
        s_stream_end <= e;
        do @(posedge aclk); while (!s_ready);
        bytes_sent++;
        predict_header_field(b, e, has, f);
        if (has) pending_fields.push_back(f);
        @(negedge aclk);
    endtask

    task automatic send_le(input logic [31:0] v, input int n);
        for (int i = 0; i < n; i++) send_byte(v[8*i +: 8], 1'b0);
    endtask

    task automatic send_filler(input int n);
        repeat (n) send_byte(8'($urandom_range(0, 255)), 1'b0);
    endtask

    task automatic send_header(input logic [15:0] ver, flg, mth, tm, dt,
                               input logic [31:0] crc, csz, usz,
                               input logic [15:0] nlen, xlen);
        send_le(zlhp_pkg::SIG_LOCAL, 4);
        send_le(ver, 2);
        send_le(flg, 2);
        send_le(mth, 2);
        send_le(tm, 2);
        send_le(dt, 2);
        send_le(crc, 4);
        send_le(csz, 4);
        send_le(usz, 4);
        send_le(nlen, 2);
        send_le(xlen, 2);
        records_sent++;
    endtask

    task automatic send_extra(input logic [15:0] id, input logic [15:0] sub_len);
        send_le(id, 2);
        send_le(sub_len, 2);
        send_filler(sub_len);
    endtask

    task automatic send_random_record();
        logic [15:0] nlen, xlen, id, sub_len;
        logic [31:0] csz;
        int          rem;
        case ($urandom_range(0, 7))
            0, 1:    nlen = 16'd0;
            7:       nlen = 16'($urandom_range(9, 40));
            default: nlen = 16'($urandom_range(1, 8));
        endcase
        xlen = ($urandom_range(0, 2) == 0) ? 16'd0 : 16'($urandom_range(1, 30));
        csz  = ($urandom_range(0, 3) == 0) ? 32'd0 : 32'($urandom_range(1, 24));
        send_header(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                    16'($urandom), $urandom, csz, $urandom, nlen, xlen);
        send_filler(nlen);
        rem = xlen;
        while (rem > 0) begin
            case ($urandom_range(0, 3))
                0:       id = zlhp_pkg::ID_TIMESTAMP;
                1:       id = zlhp_pkg::ID_UNIX;
                default: id = 16'($urandom);
            endcase
            if ($urandom_range(0, 4) == 0) sub_len = 16'(rem + $urandom_range(0, 4));
            else sub_len = 16'($urandom_range(0, rem));
            send_extra(id, sub_len);
            rem = (sub_len + 4 >= rem) ? 0 : rem - sub_len - 4;
        end
        send_filler(csz);
    endtask

    // ---------------------------------------------------------------- receiver
    always @(negedge aclk) begin
        if (calm) stall_left = 0;
        else if (stall_left == 0 && $urandom_range(0, 5) == 0)
            stall_left = $urandom_range(1, 10);
        if (stall_left != 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    task automatic check_field(input string name, input logic [31:0] want, got);
        if (got !== want) begin
            fails++;
            if (fails <= PRINT_LIMIT)
                $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
        end
    endtask

    always @(posedge aclk) begin
        hdr_field_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_fields.size() == 0) begin
                fails++;
                if (fails <= PRINT_LIMIT)
                    $display("%0t: unexpected result, expected none, got code %0d value %h",
                             $time, m_field_code, m_field_value);
            end else begin
                want = pending_fields.pop_front();
                fields_checked++;
                check_field("field_code", 32'(want.code), 32'(m_field_code));
                check_field("field_value", want.value, m_field_value);
                check_field("hour_or_year", 32'(want.hour_year), 32'(m_hour_or_year));
                check_field("minute_or_month", 32'(want.min_month),
                            32'(m_minute_or_month));
                check_field("second_or_day", 32'(want.sec_day), 32'(m_second_or_day));
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time,
                     pending_fields.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------- tests
    task automatic test_field_extremes();
        send_header(16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 32'h0, 32'h0, 32'h0, 16'h0, 16'h0);
        send_header(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF,
                    32'd2, 32'hFFFF_FFFF, 16'd2, 16'd0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_filler(2);
    endtask

    task automatic test_extra_kinds();
        send_header(16'd20, 16'h0808, 16'd8, 16'h6B5A, 16'h5A21, $urandom,
                    32'd0, $urandom, 16'd0, 16'd13);
        send_extra(zlhp_pkg::ID_TIMESTAMP, 16'd0);
        send_extra(zlhp_pkg::ID_UNIX, 16'd1);
        send_extra(16'h0001, 16'd7);
        // id and length read in full though only two bytes remain
        send_header(16'd10, 16'h0, 16'h0, 16'h0, 16'h0, $urandom,
                    32'd1, $urandom, 16'd1, 16'd2);
        send_filler(1);
        send_extra(16'hCAFE, 16'd0);
        send_filler(1);
    endtask

    task automatic test_random_records();
        while (bytes_sent < RANDOM_BYTES) begin
            calm = ($urandom_range(0, 4) == 0);
            send_random_record();
        end
    endtask

    task automatic test_calm_tail();
        calm = 1'b1;
        while (bytes_sent < TOTAL_BYTES) send_random_record();
    endtask

    task automatic test_termination();
        logic [31:0] sig;
        case ($urandom_range(0, 4))
            0: begin
                ending_kind = "stream end between records";
                send_byte(8'($urandom), 1'b1);
            end
            1: begin
                ending_kind = "stream end inside a header";
                send_le(zlhp_pkg::SIG_LOCAL, 4);
                send_filler($urandom_range(0, 25));
                send_byte(8'($urandom), 1'b1);
            end
            2: begin
                ending_kind = "zero signature";
                send_le(32'h0, 4);
            end
            3: begin
                ending_kind = "unknown signature";
                sig = $urandom;
                if (sig == 32'h0 || sig == zlhp_pkg::SIG_LOCAL) sig = sig ^ 32'h8000_0001;
                send_le(sig, 4);
            end
            default: begin
                ending_kind = "stream end inside skipped data";
                send_header(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                            16'($urandom), $urandom, $urandom | 32'h0100_0000, $urandom,
                            16'd0, 16'd0);
                send_filler($urandom_range(1, 20));
                send_byte(8'($urandom), 1'b1);
            end
        endcase
        // parser is stopped: these beats must produce nothing
        repeat ($urandom_range(3, 8)) send_byte(8'($urandom), 1'($urandom));
        send_byte(8'($urandom), 1'b1);
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_field_extremes();
        test_extra_kinds();
        test_random_records();
        test_calm_tail();
        test_termination();
        s_valid <= 1'b0;

        while (pending_fields.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);

        $display("Parsed %0d local headers over %0d stream beats; %0d fields checked.",
                 records_sent, bytes_sent, fields_checked);
        $display("Stream closed by %s; %0d mismatches.", ending_kind, fails);
        if (fails == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ===== zip_local_header_parser_unit.f =====
src/zlhp_pkg.sv
src/zip_local_header_parser_unit.sv
src/zlhp_checker.sv
sim/tb_zip_local_header_parser_unit.sv
